### rtl/core/tpra_pkg.sv
// shared types and constants of the three-pool register allocator
package tpra_pkg;

	localparam int NUM_W = 5;
	localparam int OP_W  = 2;

	localparam int PARAM_POOL_SIZE   = 8;
	localparam int GENERAL_POOL_SIZE = 7;
	localparam int CALLEE_POOL_SIZE  = 10;

	localparam logic [NUM_W-1:0] PARAM_BASE   = 5'd0;
	localparam logic [NUM_W-1:0] GENERAL_BASE = 5'd9;
	localparam logic [NUM_W-1:0] CALLEE_BASE  = 5'd19;

	typedef enum logic [OP_W-1:0] {
		OP_ALLOC_PARAM   = 2'd0,
		OP_ALLOC_GENERAL = 2'd1,
		OP_ALLOC_CALLEE  = 2'd2,
		OP_FREE          = 2'd3
	} op_t;

	typedef struct packed {
		logic             alloc;
		logic             release_en;
		logic [NUM_W-1:0] number;
	} pool_cmd_t;

	typedef struct packed {
		logic             alloc_ok;
		logic [NUM_W-1:0] alloc_number;
		logic             free_hit;
	} pool_stat_t;

endpackage

### rtl/core/tpra_req_if.sv
// request channel of the allocator
interface tpra_req_if;
	logic                      valid;
	logic                      ready;
	logic [tpra_pkg::OP_W-1:0]  op;
	logic [tpra_pkg::NUM_W-1:0] free_number;

	modport source (output valid, output op, output free_number, input ready);
	modport sink   (input valid, input op, input free_number, output ready);
endinterface

### rtl/core/tpra_rsp_if.sv
// response channel of the allocator
interface tpra_rsp_if;
	logic                      valid;
	logic                      ready;
	logic                      granted;
	logic [tpra_pkg::NUM_W-1:0] granted_number;

	modport source (output valid, output granted, output granted_number, input ready);
	modport sink   (input valid, input granted, input granted_number, output ready);
endinterface

### rtl/core/three_pool_register_allocator.sv
// three-pool register allocator top level
// a request reaches the response through the input register and then the result register
// throughput: one request per cycle while the response is taken, bitmap update and grant in the same cycle
// the three free bitmaps feed back into the next request with no bubble
// reset: arst_n clears both stages and marks every register of every pool free
module three_pool_register_allocator #(
	parameter int PARAM_POOL_SIZE   = tpra_pkg::PARAM_POOL_SIZE,
	parameter int GENERAL_POOL_SIZE = tpra_pkg::GENERAL_POOL_SIZE,
	parameter int CALLEE_POOL_SIZE  = tpra_pkg::CALLEE_POOL_SIZE
) (
	input  logic        clk,
	input  logic        arst_n,
	tpra_req_if.sink    req,
	tpra_rsp_if.source  rsp
);

	logic                       valid_s1;
	tpra_pkg::op_t              op_s1;
	logic [tpra_pkg::NUM_W-1:0] num_s1;

	logic                       rsp_valid_q;
	logic                       granted_q;
	logic [tpra_pkg::NUM_W-1:0] number_q;

	logic                       adv;
	logic                       granted_d;
	logic [tpra_pkg::NUM_W-1:0] number_d;

	tpra_pkg::pool_cmd_t  param_cmd, general_cmd, callee_cmd;
	tpra_pkg::pool_stat_t param_stat, general_stat, callee_stat;

	assign adv       = valid_s1 && (!rsp_valid_q || rsp.ready);
	assign req.ready = !valid_s1 || adv;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.valid && req.ready) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			op_s1  <= tpra_pkg::op_t'(req.op);
			num_s1 <= req.free_number;
		end
	end

	// pool commands
	always_comb begin
		param_cmd.alloc        = adv && (op_s1 == tpra_pkg::OP_ALLOC_PARAM);
		general_cmd.alloc      = adv && (op_s1 == tpra_pkg::OP_ALLOC_GENERAL);
		callee_cmd.alloc       = adv && (op_s1 == tpra_pkg::OP_ALLOC_CALLEE);
		param_cmd.release_en   = adv && (op_s1 == tpra_pkg::OP_FREE);
		general_cmd.release_en = param_cmd.release_en;
		callee_cmd.release_en  = param_cmd.release_en;
		param_cmd.number       = num_s1;
		general_cmd.number     = num_s1;
		callee_cmd.number      = num_s1;
	end

	tpra_pool #(.SIZE(PARAM_POOL_SIZE), .BASE(tpra_pkg::PARAM_BASE)) u_param_pool (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (param_cmd),
		.stat   (param_stat)
	);

	tpra_pool #(.SIZE(GENERAL_POOL_SIZE), .BASE(tpra_pkg::GENERAL_BASE)) u_general_pool (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (general_cmd),
		.stat   (general_stat)
	);

	tpra_pool #(.SIZE(CALLEE_POOL_SIZE), .BASE(tpra_pkg::CALLEE_BASE)) u_callee_pool (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (callee_cmd),
		.stat   (callee_stat)
	);

	// response select
	always_comb begin
		granted_d = 1'b0;
		number_d  = '0;
		unique case (op_s1)
			tpra_pkg::OP_ALLOC_PARAM: begin
				granted_d = param_stat.alloc_ok;
				number_d  = param_stat.alloc_ok ? param_stat.alloc_number : '0;
			end
			tpra_pkg::OP_ALLOC_GENERAL: begin
				granted_d = general_stat.alloc_ok;
				number_d  = general_stat.alloc_ok ? general_stat.alloc_number : '0;
			end
			tpra_pkg::OP_ALLOC_CALLEE: begin
				granted_d = callee_stat.alloc_ok;
				number_d  = callee_stat.alloc_ok ? callee_stat.alloc_number : '0;
			end
			tpra_pkg::OP_FREE: begin
				granted_d = param_stat.free_hit || general_stat.free_hit ||
					callee_stat.free_hit;
				number_d  = '0;
			end
			default: begin
				granted_d = 1'b0;
				number_d  = '0;
			end
		endcase
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (adv) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			granted_q <= granted_d;
			number_q  <= number_d;
		end
	end

	assign rsp.valid          = rsp_valid_q;
	assign rsp.granted        = granted_q;
	assign rsp.granted_number = number_q;

	a_no_number_without_grant: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.granted |-> rsp.granted_number == '0)
		else $error("response number set without grant");

	a_accept_fills_stage: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> valid_s1)
		else $error("accepted request lost before result stage");

	a_stalled_stage_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv |=> valid_s1 && $stable(op_s1) && $stable(num_s1))
		else $error("stalled request changed");

	a_one_pool_alloc: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({param_cmd.alloc, general_cmd.alloc, callee_cmd.alloc,
			param_cmd.release_en}))
		else $error("more than one pool command in a cycle");

endmodule

### rtl/core/tpra_pool.sv
// one register pool: free bitmap, lowest-free grant and release
module tpra_pool #(
	parameter int                          SIZE = 8,
	parameter logic [tpra_pkg::NUM_W-1:0] BASE = '0
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  tpra_pkg::pool_cmd_t    cmd,
	output tpra_pkg::pool_stat_t   stat
);

	localparam int IW = (SIZE > 1) ? $clog2(SIZE) : 1;
	localparam logic [tpra_pkg::NUM_W:0] LIMIT =
		(tpra_pkg::NUM_W+1)'(int'(BASE) + SIZE);

	logic [SIZE-1:0]           free_map_q;
	logic [SIZE-1:0]           low_bit;
	logic [SIZE-1:0]           set_mask;
	logic [IW-1:0]             low_idx;
	logic [tpra_pkg::NUM_W-1:0] offset;
	logic                      in_range;

	// lowest free entry
	always_comb begin
		low_bit = free_map_q & (~free_map_q + SIZE'(1));
		low_idx = '0;
		for (int i = 0; i < SIZE; i++) begin
			if (low_bit[i]) begin
				low_idx = IW'(i);
			end
		end
	end

	// release decode
	always_comb begin
		in_range = (cmd.number >= BASE) && ({1'b0, cmd.number} < LIMIT);
		offset   = cmd.number - BASE;
		set_mask = '0;
		for (int i = 0; i < SIZE; i++) begin
			if (offset == tpra_pkg::NUM_W'(i)) begin
				set_mask[i] = 1'b1;
			end
		end
	end

	assign stat.alloc_ok     = |free_map_q;
	assign stat.alloc_number = BASE + tpra_pkg::NUM_W'(low_idx);
	assign stat.free_hit     = in_range;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_map_q <= '1;
		end else if (cmd.alloc) begin
			free_map_q <= free_map_q & ~low_bit;
		end else if (cmd.release_en && in_range) begin
			free_map_q <= free_map_q | set_mask;
		end
	end

endmodule
